/* rtl/ps2mpt_pkg.sv */
// ps2mpt_pkg: shared types, constants and helpers of the ps/2 mouse packet tracker
// used by ps2mpt_regs and ps2_mouse_packet_tracker_top; no dependencies
`default_nettype none

package ps2mpt_pkg;

    // default cursor coordinate width
    localparam int COORD_BITS_DEF = 16;

    // width of the screen size registers and of the apb bus
    localparam int SIZE_BITS = 16;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // reset screen size
    localparam logic [SIZE_BITS-1:0] WIDTH_RESET = 16'd1024;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 16'd768;

    // register index, taken from paddr bit 2
    localparam logic REG_WIDTH = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // header byte bit positions
    localparam int HDR_ALWAYS_ONE = 3;
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;
    localparam int HDR_X_OVF = 6;
    localparam int HDR_Y_OVF = 7;

    // magnitude of a movement, up to 255 + 255
    localparam int MAG_BITS = 9;
    localparam logic [MAG_BITS-1:0] OVF_EXTRA = 9'd255;

    // screen size as seen by the tracker
    typedef struct packed {
        logic [SIZE_BITS-1:0] width;
        logic [SIZE_BITS-1:0] height;
    } t_cfg;

    // movement byte magnitude: byte or two's complement when negative, +255 on overflow
    function automatic logic [MAG_BITS-1:0] move_mag(input logic [7:0] b,
                                                     input logic neg,
                                                     input logic ovf);
        logic [7:0] m;
        m = neg ? 8'(~b + 8'd1) : b;
        return {1'b0, m} + (ovf ? OVF_EXTRA : {MAG_BITS{1'b0}});
    endfunction

endpackage

`default_nettype wire

/* rtl/ps2_mouse_packet_tracker_top.sv */
// ps2_mouse_packet_tracker_top: frames ps/2 mouse bytes into packets and tracks the cursor
// depends on ps2mpt_pkg and ps2mpt_regs
`default_nettype none

// The tracker takes one mouse byte per beat and can accept a byte in every clock
// cycle unless o_in_stall is raised. The first byte after reset is dropped; after
// that bytes are framed as header, X movement and Y movement, and a header whose
// always-one bit 3 is clear is dropped. The Y byte completes a packet: the cursor
// position is moved, Y inverted, clamped to the screen size from the registers,
// and one result beat with the position and raw header leaves the output register
// in the cycle after that byte is accepted. Bytes are taken while a result waits;
// o_in_stall is raised only when a result is waiting under i_out_stall and the
// next byte would complete another packet. Register writes take effect from the
// next completed packet; width is at address 0 and height at address 4.

module ps2_mouse_packet_tracker_top #(
    parameter int COORD_BITS = ps2mpt_pkg::COORD_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // byte channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [7:0]                            i_data_byte,
    // result channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic      [15:0]                           o_cursor_x,
    output logic      [15:0]                           o_cursor_y,
    output logic      [7:0]                            o_header_flags,
    // configuration
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [ps2mpt_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [ps2mpt_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [ps2mpt_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                       pready
);

    // working width: signed, holds position plus movement and the size limit
    localparam int CW = (COORD_BITS + 2 > ps2mpt_pkg::SIZE_BITS + 1) ?
                        COORD_BITS + 2 : ps2mpt_pkg::SIZE_BITS + 1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XBYTE  = 2'd1,
        PH_YBYTE  = 2'd2
    } t_phase;

    ps2mpt_pkg::t_cfg cfg;

    ps2mpt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // state
    logic                  r_skip;
    t_phase                r_phase;
    logic [7:0]            r_held_h;
    logic [7:0]            r_held_x;
    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;
    logic                  r_out_valid;
    logic [15:0]           r_out_x;
    logic [15:0]           r_out_y;
    logic [7:0]            r_out_h;

    logic                  n_skip;
    t_phase                n_phase;
    logic [7:0]            n_held_h;
    logic [7:0]            n_held_x;
    logic [COORD_BITS-1:0] n_pos_x;
    logic [COORD_BITS-1:0] n_pos_y;
    logic                  n_out_valid;
    logic                  load_out;

    logic                  in_acc;
    logic                  completes;

    // movement and clamp datapath
    logic [ps2mpt_pkg::MAG_BITS-1:0] mag_x;
    logic [ps2mpt_pkg::MAG_BITS-1:0] mag_y;
    logic signed [CW-1:0]            x_sum;
    logic signed [CW-1:0]            y_sum;
    logic signed [CW-1:0]            cmax;
    logic signed [CW-1:0]            lim_x;
    logic signed [CW-1:0]            lim_y;
    logic [ps2mpt_pkg::SIZE_BITS-1:0] w_m1;
    logic [ps2mpt_pkg::SIZE_BITS-1:0] h_m1;
    logic [COORD_BITS-1:0]           x_clamped;
    logic [COORD_BITS-1:0]           y_clamped;

    // a byte completes a packet only in the y phase after the skip
    assign completes  = !r_skip && (r_phase == PH_YBYTE);
    assign o_in_stall = r_out_valid && i_out_stall && completes;
    assign in_acc     = i_in_valid && !o_in_stall;

    // signed movements, y inverted for screen rows
    always_comb begin
        mag_x = ps2mpt_pkg::move_mag(r_held_x, r_held_h[ps2mpt_pkg::HDR_X_SIGN],
                                     r_held_h[ps2mpt_pkg::HDR_X_OVF]);
        mag_y = ps2mpt_pkg::move_mag(i_data_byte, r_held_h[ps2mpt_pkg::HDR_Y_SIGN],
                                     r_held_h[ps2mpt_pkg::HDR_Y_OVF]);
        x_sum = r_held_h[ps2mpt_pkg::HDR_X_SIGN] ?
                $signed(CW'(r_pos_x)) - $signed(CW'(mag_x)) :
                $signed(CW'(r_pos_x)) + $signed(CW'(mag_x));
        y_sum = r_held_h[ps2mpt_pkg::HDR_Y_SIGN] ?
                $signed(CW'(r_pos_y)) + $signed(CW'(mag_y)) :
                $signed(CW'(r_pos_y)) - $signed(CW'(mag_y));
    end

    // limits: size minus one, zero for size zero, capped at the coordinate range
    always_comb begin
        cmax  = $signed(CW'({COORD_BITS{1'b1}}));
        w_m1  = (cfg.width == '0) ? '0 : cfg.width - 1'b1;
        h_m1  = (cfg.height == '0) ? '0 : cfg.height - 1'b1;
        lim_x = $signed(CW'(w_m1));
        lim_y = $signed(CW'(h_m1));
        if (lim_x > cmax) lim_x = cmax;
        if (lim_y > cmax) lim_y = cmax;
    end

    // clamp to the screen
    always_comb begin
        if (x_sum < 0) begin
            x_clamped = '0;
        end else if (x_sum > lim_x) begin
            x_clamped = lim_x[COORD_BITS-1:0];
        end else begin
            x_clamped = x_sum[COORD_BITS-1:0];
        end
        if (y_sum < 0) begin
            y_clamped = '0;
        end else if (y_sum > lim_y) begin
            y_clamped = lim_y[COORD_BITS-1:0];
        end else begin
            y_clamped = y_sum[COORD_BITS-1:0];
        end
    end

    // packet framing
    always_comb begin
        n_skip      = r_skip;
        n_phase     = r_phase;
        n_held_h    = r_held_h;
        n_held_x    = r_held_x;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        load_out    = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        if (in_acc) begin
            if (r_skip) begin
                n_skip = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_XBYTE: begin
                        n_held_x = i_data_byte;
                        n_phase  = PH_YBYTE;
                    end
                    PH_YBYTE: begin
                        n_pos_x     = x_clamped;
                        n_pos_y     = y_clamped;
                        n_phase     = PH_HEADER;
                        load_out    = 1'b1;
                        n_out_valid = 1'b1;
                    end
                    default: begin
                        if (i_data_byte[ps2mpt_pkg::HDR_ALWAYS_ONE]) begin
                            n_held_h = i_data_byte;
                            n_phase  = PH_XBYTE;
                        end else begin
                            n_phase  = PH_HEADER;
                        end
                    end
                endcase
            end
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip      <= 1'b1;
            r_phase     <= PH_HEADER;
            r_held_h    <= '0;
            r_held_x    <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_skip      <= n_skip;
            r_phase     <= n_phase;
            r_held_h    <= n_held_h;
            r_held_x    <= n_held_x;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_out_valid <= n_out_valid;
        end
        if (load_out) begin
            r_out_x <= 16'(n_pos_x);
            r_out_y <= 16'(n_pos_y);
            r_out_h <= r_held_h;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cursor_x     = r_out_x;
    assign o_cursor_y     = r_out_y;
    assign o_header_flags = r_out_h;

    // a new result only comes from a completing byte
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_acc && completes))
        else $error("result beat without a completing y byte");

    // the skip is over after the first accepted byte
    a_skip_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !r_skip)
        else $error("first byte skip still set after an accepted byte");

    // a header held for the x byte has its always-one bit
    a_header_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_XBYTE) |-> r_held_h[ps2mpt_pkg::HDR_ALWAYS_ONE])
        else $error("header held without its always-one bit");

    // byte stall only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && r_phase == PH_YBYTE))
        else $error("byte stall without a waiting result");

endmodule

`default_nettype wire

/* rtl/ps2mpt_regs.sv */
// ps2mpt_regs: apb register file holding the screen width and height
// depends on ps2mpt_pkg
`default_nettype none

module ps2mpt_regs (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [ps2mpt_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [ps2mpt_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [ps2mpt_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                       pready,
    output ps2mpt_pkg::t_cfg                           o_cfg
);

    logic [ps2mpt_pkg::SIZE_BITS-1:0] r_width;
    logic [ps2mpt_pkg::SIZE_BITS-1:0] r_height;
    logic                             wr_en;
    logic                             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ps2mpt_pkg::WIDTH_RESET;
            r_height <= ps2mpt_pkg::HEIGHT_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                ps2mpt_pkg::REG_WIDTH:  r_width  <= pwdata[ps2mpt_pkg::SIZE_BITS-1:0];
                ps2mpt_pkg::REG_HEIGHT: r_height <= pwdata[ps2mpt_pkg::SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_sel)
            ps2mpt_pkg::REG_WIDTH:  prdata = ps2mpt_pkg::APB_DATA_BITS'(r_width);
            ps2mpt_pkg::REG_HEIGHT: prdata = ps2mpt_pkg::APB_DATA_BITS'(r_height);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg.width  = r_width;
    assign o_cfg.height = r_height;

endmodule

`default_nettype wire

/* test/ps2_mouse_packet_tracker_top_tb.sv */
`timescale 1ns / 1ps
// ps2_mouse_packet_tracker_top_tb: self-checking bench for the ps/2 mouse packet tracker
// drives mouse bytes and apb screen sizes, checks cursor beats against a local tracker model
// depends on ps2mpt_pkg and ps2_mouse_packet_tracker_top

module ps2_mouse_packet_tracker_top_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS = 75;
    localparam int N_PHASES = 8;
    localparam int N_DIRECTED = 23;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  flags;
    } t_cursor_beat;

    // one directed mouse byte, with the cursor beat typed in where it is obvious
    typedef struct packed {
        logic         typed;
        logic [7:0]   data;
        t_cursor_beat want;
    } t_byte_row;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum logic [1:0] {WANT_HEADER, WANT_X, WANT_Y} t_frame_phase;

    // header probe, movement signs and overflows, clamping on both sides
    localparam t_byte_row DIRECTED [N_DIRECTED] = '{
        '{1'b0, 8'hFA, '0},
        '{1'b0, 8'hF7, '0},
        '{1'b0, 8'h08, '0},
        '{1'b0, 8'h7F, '0},
        '{1'b1, 8'h00, '{16'd127, 16'd0, 8'h08}},
        '{1'b0, 8'h28, '0},
        '{1'b0, 8'h00, '0},
        '{1'b1, 8'h9C, '{16'd127, 16'd100, 8'h28}},
        '{1'b0, 8'h18, '0},
        '{1'b0, 8'h00, '0},
        '{1'b1, 8'h01, '{16'd127, 16'd99, 8'h18}},
        '{1'b0, 8'h59, '0},
        '{1'b0, 8'h01, '0},
        '{1'b1, 8'hFF, '{16'd0, 16'd0, 8'h59}},
        '{1'b0, 8'hEF, '0},
        '{1'b0, 8'hFF, '0},
        '{1'b1, 8'h01, '{16'd510, 16'd510, 8'hEF}},
        '{1'b0, 8'hEF, '0},
        '{1'b0, 8'hFF, '0},
        '{1'b1, 8'h01, '{16'd1020, 16'd767, 8'hEF}},
        '{1'b0, 8'hEF, '0},
        '{1'b0, 8'hFF, '0},
        '{1'b1, 8'h01, '{16'd1023, 16'd767, 8'hEF}}
    };

    // screen sizes per phase; the last two phases draw random sizes
    localparam logic [15:0] PHASE_W [N_PHASES] = '{
        16'd1, 16'd65535, 16'd0, 16'd17, 16'd65535, 16'd640, 16'd0, 16'd0
    };
    localparam logic [15:0] PHASE_H [N_PHASES] = '{
        16'd1, 16'd65535, 16'd0, 16'd9, 16'd1, 16'd480, 16'd0, 16'd0
    };

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_stall;
    logic [7:0]                            i_data_byte = 8'h00;
    logic                                  o_out_valid;
    logic                                  i_out_stall = 1'b0;
    logic [15:0]                           o_cursor_x;
    logic [15:0]                           o_cursor_y;
    logic [7:0]                            o_header_flags;
    logic                                  psel = 1'b0;
    logic                                  penable = 1'b0;
    logic                                  pwrite = 1'b0;
    logic [ps2mpt_pkg::APB_ADDR_BITS-1:0]  paddr = '0;
    logic [ps2mpt_pkg::APB_DATA_BITS-1:0]  pwdata = '0;
    logic [ps2mpt_pkg::APB_DATA_BITS-1:0]  prdata;
    logic                                  pready;

    ps2_mouse_packet_tracker_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cursor_x     (o_cursor_x),
        .o_cursor_y     (o_cursor_y),
        .o_header_flags (o_header_flags),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // tracker model state
    logic         skip_next = 1'b1;
    t_frame_phase frame_phase = WANT_HEADER;
    logic [7:0]   saved_header = 8'h00;
    logic [7:0]   saved_dx = 8'h00;
    int           cur_x = 0;
    int           cur_y = 0;
    int unsigned  scr_width = ps2mpt_pkg::WIDTH_RESET;
    int unsigned  scr_height = ps2mpt_pkg::HEIGHT_RESET;

    t_cursor_beat cursor_queue [$];
    t_idle_mode   idle_mode = IDLE_NONE;
    int           errors = 0;
    int           cycle_count = 0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // movement size of one byte, sign taken as two's complement, overflow adds 255
    function automatic int move_size(input logic [7:0] b, input logic neg, input logic ovf);
        int m;
        m = neg ? ((256 - int'(b)) & 255) : int'(b);
        return ovf ? m + 255 : m;
    endfunction

    // keep a coordinate within 0 .. size - 1; zero size pins it at 0
    function automatic int clamp_to(input int v, input int unsigned size);
        int lim;
        lim = (size == 0) ? 0 : int'(size) - 1;
        if (v < 0)
            return 0;
        return (v > lim) ? lim : v;
    endfunction

    // advance the tracker model by one byte; returns 1 when a cursor beat is due
    function automatic logic track_byte(input logic [7:0] b, output t_cursor_beat beat);
        logic done;
        int   nx;
        int   ny;
        done = 1'b0;
        beat = '0;
        if (skip_next) begin
            skip_next = 1'b0;
        end else begin
            case (frame_phase)
                WANT_X: begin
                    saved_dx = b;
                    frame_phase = WANT_Y;
                end
                WANT_Y: begin
                    nx = move_size(saved_dx, saved_header[ps2mpt_pkg::HDR_X_SIGN],
                                   saved_header[ps2mpt_pkg::HDR_X_OVF]);
                    ny = move_size(b, saved_header[ps2mpt_pkg::HDR_Y_SIGN],
                                   saved_header[ps2mpt_pkg::HDR_Y_OVF]);
                    nx = saved_header[ps2mpt_pkg::HDR_X_SIGN] ? cur_x - nx : cur_x + nx;
                    ny = saved_header[ps2mpt_pkg::HDR_Y_SIGN] ? cur_y + ny : cur_y - ny;
                    cur_x = clamp_to(nx, scr_width);
                    cur_y = clamp_to(ny, scr_height);
                    frame_phase = WANT_HEADER;
                    beat = '{16'(cur_x), 16'(cur_y), saved_header};
                    done = 1'b1;
                end
                default: begin
                    if (b[ps2mpt_pkg::HDR_ALWAYS_ONE]) begin
                        saved_header = b;
                        frame_phase = WANT_X;
                    end else begin
                        frame_phase = WANT_HEADER;
                    end
                end
            endcase
        end
        return done;
    endfunction

    function automatic logic sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99) < 61;
            IDLE_BOTH:   return $urandom_range(99) < 36;
            default:     return 1'b0;
        endcase
    endfunction

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // cursor beat check and receiver stall
    always @(posedge i_clk) begin : cursor_check
        t_cursor_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cursor_queue.size() == 0) begin
                $display("%0t: unexpected cursor beat, expected none, %s x=%0d y=%0d flags=%02h",
                         $time, "actual", o_cursor_x, o_cursor_y, o_header_flags);
                errors++;
            end else begin
                want = cursor_queue.pop_front();
                report_field("cursor_x", want.x, o_cursor_x);
                report_field("cursor_y", want.y, o_cursor_y);
                report_field("header_flags", want.flags, o_header_flags);
            end
        end
        case (idle_mode)
            IDLE_RECEIVER: i_out_stall <= ($urandom_range(99) < 61);
            IDLE_BOTH:     i_out_stall <= ($urandom_range(99) < 36);
            default:       i_out_stall <= 1'b0;
        endcase
    end

    // one mouse byte beat; valid stays high into the next call unless a gap is drawn
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input t_cursor_beat typed_beat);
        t_cursor_beat beat;
        if (sender_idles()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (sender_idles()) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (track_byte(b, beat))
            cursor_queue.push_back(typed ? typed_beat : beat);
    endtask

    // one apb transfer: setup, then access until pready
    task automatic apb_access(input logic wr, input logic idx,
                              input logic [ps2mpt_pkg::APB_DATA_BITS-1:0] wdata,
                              output logic [ps2mpt_pkg::APB_DATA_BITS-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write both screen sizes and read them back
    task automatic set_screen(input logic [15:0] w, input logic [15:0] h);
        logic [ps2mpt_pkg::APB_DATA_BITS-1:0] rd;
        logic [15:0]                          sizes [2];
        sizes[0] = w;
        sizes[1] = h;
        apb_access(1'b1, ps2mpt_pkg::REG_WIDTH, ps2mpt_pkg::APB_DATA_BITS'(w), rd);
        apb_access(1'b1, ps2mpt_pkg::REG_HEIGHT, ps2mpt_pkg::APB_DATA_BITS'(h), rd);
        scr_width = w;
        scr_height = h;
        for (int i = 0; i < 2; i++) begin
            apb_access(1'b0, i[0], '0, rd);
            if (rd != ps2mpt_pkg::APB_DATA_BITS'(sizes[i])) begin
                $display("%0t: register %0d readback, expected %0d, actual %0d",
                         $time, i, sizes[i], rd);
                errors++;
            end
        end
    endtask

    // stop sending, wait for every pending cursor beat and the block's latency
    task automatic settle();
        i_in_valid <= 1'b0;
        while (cursor_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed packets with random content, some stray bytes between them
    task automatic run_traffic(input int n);
        int         sent;
        logic [7:0] hdr;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 85) begin
                hdr = 8'($urandom_range(255));
                hdr[ps2mpt_pkg::HDR_ALWAYS_ONE] = 1'b1;
                send_byte(hdr, 1'b0, '0);
                send_byte(8'($urandom_range(255)), 1'b0, '0);
                send_byte(8'($urandom_range(255)), 1'b0, '0);
                sent += 3;
            end else begin
                send_byte(8'($urandom_range(255)), 1'b0, '0);
            end
        end
    endtask

    initial begin : stimulus
        logic [15:0] w;
        logic [15:0] h;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed bytes at reset screen size
        for (int k = 0; k < N_DIRECTED; k++)
            send_byte(DIRECTED[k].data, DIRECTED[k].typed, DIRECTED[k].want);

        // random phases over screen sizes and idle patterns
        for (int k = 0; k < N_PHASES; k++) begin
            settle();
            w = (k >= 6) ? 16'($urandom_range(65535, 1)) : PHASE_W[k];
            h = (k >= 6) ? 16'($urandom_range(65535, 1)) : PHASE_H[k];
            set_screen(w, h);
            idle_mode = t_idle_mode'(k % 4);
            run_traffic(PHASE_ITEMS);
        end
        settle();

        if (errors == 0 && cursor_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ps2mpt_pkg.sv
rtl/ps2mpt_regs.sv
rtl/ps2_mouse_packet_tracker_top.sv
test/ps2_mouse_packet_tracker_top_tb.sv
